// ----- rtl/h264fr_pkg.sv -----
// Package for the H.264 RTP fragmenter: constants, register codes and the
// state and result structs shared by the step logic and the top level.
// No dependencies.
package h264fr_pkg;

    localparam int unsigned MAX_NAL_LENGTH = 65535;
    localparam logic [23:0] MAX_NAL_LENGTH_W = 24'(MAX_NAL_LENGTH);

    localparam logic [15:0] MAX_PAYLOAD_RESET    = 16'd1400;
    localparam logic [16:0] TIMESTAMP_STEP_RESET = 17'd3600;

    localparam logic [7:0] NAL_TYPE_MASK = 8'h1F;
    localparam logic [7:0] NAL_NRI_MASK  = 8'h60;
    localparam logic [7:0] FU_A_TYPE     = 8'd28;
    localparam logic [7:0] FU_START_BIT  = 8'h80;
    localparam logic [7:0] FU_END_BIT    = 8'h40;
    localparam logic [4:0] NAL_TYPE_SPS  = 5'd7;
    localparam logic [4:0] NAL_TYPE_PPS  = 5'd8;

    // Register select: bit 2 of the byte address.
    localparam logic REG_MAX_PAYLOAD    = 1'b0;
    localparam logic REG_TIMESTAMP_STEP = 1'b1;

    typedef struct packed {
        logic [7:0]  header_hold;
        logic [15:0] bytes_left;
        logic [15:0] fragment_fill;
        logic        fragmenting;
        logic        first_fragment;
        logic [15:0] seq_count;
        logic [31:0] time_count;
    } frag_state_t;

    // Results of one item, entry 0 goes out first.
    typedef struct packed {
        logic [1:0]      count;
        logic [2:0][7:0] res_byte;
        logic [2:0]      res_start;
        logic [2:0]      res_end;
    } step_res_t;

endpackage

// ----- rtl/h264fr_if.sv -----
// Stream interfaces of the H.264 RTP fragmenter: NAL bytes in, packet
// bytes out. Valid/ready handshake. Depends on nothing.
interface h264fr_nal_if;
    logic        valid;
    logic        ready;
    logic [7:0]  nal_byte;
    logic [15:0] nal_length;
    logic        first_byte;

    modport source (output valid, output nal_byte, output nal_length,
                    output first_byte, input ready);
    modport sink   (input valid, input nal_byte, input nal_length,
                    input first_byte, output ready);
endinterface

interface h264fr_pkt_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        packet_start;
    logic        packet_end;
    logic [15:0] sequence_res;
    logic [31:0] stamp;
    logic        last;

    modport source (output valid, output out_byte, output packet_start,
                    output packet_end, output sequence_res, output stamp,
                    output last, input ready);
    modport sink   (input valid, input out_byte, input packet_start,
                    input packet_end, input sequence_res, input stamp,
                    input last, output ready);
endinterface

// ----- rtl/h264fr_step.sv -----
// Per-byte packetizer logic: next state and up to three results.
// Depends on h264fr_pkg.
module h264fr_step (
    input  logic [7:0]               nal_byte,
    input  logic [15:0]              nal_length,
    input  logic                     first_byte,
    input  logic [15:0]              max_payload,
    input  logic [16:0]              timestamp_step,
    input  h264fr_pkg::frag_state_t  state_cur,
    output h264fr_pkg::frag_state_t  state_next,
    output h264fr_pkg::step_res_t    res
);
    import h264fr_pkg::*;

    logic [15:0] mp;
    logic [15:0] len_fix;
    logic [15:0] left_dec;
    logic [15:0] fill_inc;
    logic [31:0] time_add;
    logic [4:0]  b_type;
    logic [4:0]  h_type;
    logic        pend;
    logic [7:0]  fu_hdr;

    always_comb
    begin
        mp       = (max_payload == 16'd0) ? 16'd1 : max_payload;
        len_fix  = (nal_length == 16'd0) ? 16'd1 : nal_length;
        if ({8'd0, len_fix} > MAX_NAL_LENGTH_W)
        begin
            len_fix = MAX_NAL_LENGTH_W[15:0];
        end
        left_dec = state_cur.bytes_left - 16'd1;
        fill_inc = state_cur.fragment_fill + 16'd1;
        time_add = state_cur.time_count + {15'd0, timestamp_step};
        b_type   = nal_byte[4:0];
        h_type   = state_cur.header_hold[4:0];
        pend     = (fill_inc >= mp) || (left_dec == 16'd0);
        fu_hdr   = state_cur.header_hold & NAL_TYPE_MASK;
        if (state_cur.first_fragment)
        begin
            fu_hdr = fu_hdr | FU_START_BIT;
        end
        if (state_cur.bytes_left <= mp)
        begin
            fu_hdr = fu_hdr | FU_END_BIT;
        end

        state_next = state_cur;
        res        = '0;

        priority if (first_byte)
        begin
            state_next.header_hold   = nal_byte;
            state_next.fragment_fill = 16'd0;
            state_next.bytes_left    = len_fix - 16'd1;
            if (len_fix <= mp)
            begin
                state_next.fragmenting    = 1'b0;
                state_next.first_fragment = 1'b0;
                res.count        = 2'd1;
                res.res_byte[0]  = nal_byte;
                res.res_start[0] = 1'b1;
                res.res_end[0]   = (len_fix == 16'd1);
                if (len_fix == 16'd1)
                begin
                    state_next.seq_count = state_cur.seq_count + 16'd1;
                    if (b_type != NAL_TYPE_SPS && b_type != NAL_TYPE_PPS)
                    begin
                        state_next.time_count = time_add;
                    end
                end
            end
            else
            begin
                state_next.fragmenting    = 1'b1;
                state_next.first_fragment = 1'b1;
            end
        end
        else if (state_cur.bytes_left == 16'd0)
        begin
            // stray byte: drop
        end
        else if (!state_cur.fragmenting)
        begin
            res.count          = 2'd1;
            res.res_byte[0]    = nal_byte;
            res.res_end[0]     = (left_dec == 16'd0);
            state_next.bytes_left = left_dec;
            if (left_dec == 16'd0)
            begin
                state_next.seq_count = state_cur.seq_count + 16'd1;
                if (h_type != NAL_TYPE_SPS && h_type != NAL_TYPE_PPS)
                begin
                    state_next.time_count = time_add;
                end
            end
        end
        else
        begin
            if (state_cur.fragment_fill == 16'd0)
            begin
                state_next.first_fragment = 1'b0;
                res.count        = 2'd3;
                res.res_byte[0]  = (state_cur.header_hold & NAL_NRI_MASK) | FU_A_TYPE;
                res.res_start[0] = 1'b1;
                res.res_byte[1]  = fu_hdr;
                res.res_byte[2]  = nal_byte;
                res.res_end[2]   = pend;
            end
            else
            begin
                res.count        = 2'd1;
                res.res_byte[0]  = nal_byte;
                res.res_end[0]   = pend;
            end
            state_next.bytes_left    = left_dec;
            state_next.fragment_fill = pend ? 16'd0 : fill_inc;
            if (pend)
            begin
                state_next.seq_count = state_cur.seq_count + 16'd1;
            end
            if (left_dec == 16'd0)
            begin
                state_next.fragmenting = 1'b0;
                state_next.time_count  = time_add;
            end
        end
    end

endmodule

// ----- rtl/h264_rtp_fragmenter_unit.sv -----
// Top level of the H.264 RTP fragmenter (single NAL packets and FU-A).
// Depends on h264fr_pkg, h264fr_if (both interfaces) and h264fr_step.
//
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+------------------------------------------
//  nal_in   | in  | valid/ready         | nal_byte, nal_length, first_byte
//  pkt_out  | out | valid/ready         | out_byte, packet_start, packet_end,
//           |     |                     | sequence_res, stamp, last
//  apb      | cfg | psel/penable/pready | 0x0 max_payload, 0x4 timestamp_step
//
// An accepted item is worked in the cycle it is taken; its results (zero to
// three) sit in a three-entry result shift register and leave one per cycle
// while pkt_out.ready is high. A one-result byte lets the next byte in as its
// result leaves; a fragment start (three results) holds input ready low until
// two results have left. Output stalls back up into nal_in.ready once the last
// result is waiting. Reset (rst_n, async, active low) clears the packetizer
// state, the result count and loads the register defaults 1400 and 3600.
module h264_rtp_fragmenter_unit (
    input  logic         clk,
    input  logic         rst_n,
    h264fr_nal_if.sink   nal_in,
    h264fr_pkt_if.source pkt_out,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import h264fr_pkg::*;

    // Configuration registers
    logic [15:0] max_payload_reg;
    logic [16:0] timestamp_step_reg;

    // Packetizer state
    frag_state_t state_reg;
    frag_state_t state_next;
    step_res_t   step_res;

    // Result shift register: entry 0 is the one on the output
    logic [1:0]      rb_count_reg;
    logic [1:0]      rb_count_next;
    logic [2:0][7:0] rb_byte_reg;
    logic [2:0]      rb_start_reg;
    logic [2:0]      rb_end_reg;
    logic [15:0]     rb_seq_reg;
    logic [31:0]     rb_stamp_reg;

    logic in_fire;
    logic out_fire;
    logic cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[2])
            REG_MAX_PAYLOAD:    prdata = {16'd0, max_payload_reg};
            REG_TIMESTAMP_STEP: prdata = {15'd0, timestamp_step_reg};
            default:            prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg    <= MAX_PAYLOAD_RESET;
            timestamp_step_reg <= TIMESTAMP_STEP_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_MAX_PAYLOAD:    max_payload_reg    <= pwdata[15:0];
                REG_TIMESTAMP_STEP: timestamp_step_reg <= pwdata[16:0];
                default:            max_payload_reg    <= max_payload_reg;
            endcase
        end
    end

    h264fr_step u_step (
        .nal_byte       (nal_in.nal_byte),
        .nal_length     (nal_in.nal_length),
        .first_byte     (nal_in.first_byte),
        .max_payload    (max_payload_reg),
        .timestamp_step (timestamp_step_reg),
        .state_cur      (state_reg),
        .state_next     (state_next),
        .res            (step_res)
    );

    // Take a new item when the result register is empty, or when its last
    // entry leaves in this cycle.
    assign out_fire     = pkt_out.valid && pkt_out.ready;
    assign nal_in.ready = (rb_count_reg == 2'd0) ||
                          ((rb_count_reg == 2'd1) && pkt_out.ready);
    assign in_fire      = nal_in.valid && nal_in.ready;

    always_comb
    begin
        priority if (in_fire)
        begin
            rb_count_next = step_res.count;
        end
        else if (out_fire)
        begin
            rb_count_next = rb_count_reg - 2'd1;
        end
        else
        begin
            rb_count_next = rb_count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= '0;
            rb_count_reg <= 2'd0;
        end
        else
        begin
            rb_count_reg <= rb_count_next;
            if (in_fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Payload side: load on accept, advance by one entry on each output.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rb_byte_reg  <= step_res.res_byte;
            rb_start_reg <= step_res.res_start;
            rb_end_reg   <= step_res.res_end;
            // all results of one byte carry the sequence and stamp before it
            rb_seq_reg   <= state_reg.seq_count;
            rb_stamp_reg <= state_reg.time_count;
        end
        else if (out_fire)
        begin
            rb_byte_reg  <= {8'd0, rb_byte_reg[2:1]};
            rb_start_reg <= {1'b0, rb_start_reg[2:1]};
            rb_end_reg   <= {1'b0, rb_end_reg[2:1]};
        end
    end

    assign pkt_out.valid        = (rb_count_reg != 2'd0);
    assign pkt_out.out_byte     = rb_byte_reg[0];
    assign pkt_out.packet_start = rb_start_reg[0];
    assign pkt_out.packet_end   = rb_end_reg[0];
    assign pkt_out.sequence_res = rb_seq_reg;
    assign pkt_out.stamp        = rb_stamp_reg;
    assign pkt_out.last         = (rb_count_reg == 2'd1);

endmodule
